@@ rtl/radial_layer_range_lookup_top_macros.svh @@
`ifndef RADIAL_LAYER_RANGE_LOOKUP_TOP_MACROS_SVH
`define RADIAL_LAYER_RANGE_LOOKUP_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define RLRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define RLRL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rlrl_pkg.sv @@
`default_nettype none
package rlrl_pkg;

  localparam int MAX_LAYERS  = 64;
  localparam int TABLE_DEPTH = 128;
  localparam int OWNER_DEPTH = TABLE_DEPTH - 1;
  localparam int R2_W        = 32;
  localparam int TOL_W       = 16;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int LAYER_W     = 6;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int LC_W        = $clog2(MAX_LAYERS + 1);
  localparam int OWN_W       = 7;

  localparam logic [OWN_W-1:0] GAP_MARK = OWN_W'(OWNER_DEPTH);

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_APPEND,
    MODE_QUERY,
    MODE_RSVD
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD,
    ST_FULL,
    ST_NONE
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APP_GAP,
    S_APP_LAYER,
    S_Q_SMAX,
    S_Q_IMIN,
    S_Q_SMIN,
    S_Q_OA,
    S_Q_OB,
    S_Q_OC,
    S_Q_OD,
    S_Q_OE,
    S_Q_EVAL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRCH_NONE,
    SRCH_MAX,
    SRCH_MIN,
    SRCH_STEP
  } srch_t;

  typedef enum logic [2:0] {
    OWN_NONE,
    OWN_A,
    OWN_B,
    OWN_C,
    OWN_D,
    OWN_E
  } own_t;

  typedef enum logic [2:0] {
    RES_OK0,
    RES_BAD,
    RES_FULL,
    RES_NONE,
    RES_IDX,
    RES_QUERY
  } res_t;

  typedef struct packed {
    logic  latch;
    logic  clr;
    logic  gap_wr;
    logic  layer_wr;
    srch_t srch;
    logic  imax_set;
    logic  imax_dir;
    logic  imin_set;
    logic  imin_zero;
    own_t  own;
    logic  res_set;
    res_t  res;
    logic  load;
  } rlrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  a_ge_b;
    logic  full;
    logic  bc_zero;
    logic  a_lt_last;
    logic  a_gt_tol;
    logic  q_empty;
    logic  q_outside;
    logic  hi_lt_rmax;
    logic  lo_ge_rmin;
    logic  srch_done;
    logic  out_free;
  } rlrl_sts_t;

endpackage
`default_nettype wire

@@ rtl/rlrl_if.sv @@
`default_nettype none
interface rlrl_req_if;
  logic                         valid;
  logic                         ready;
  logic [rlrl_pkg::MODE_W-1:0]  mode;
  logic [rlrl_pkg::R2_W-1:0]    inner_r2;
  logic [rlrl_pkg::R2_W-1:0]    outer_r2;

  modport source (output valid, output mode, output inner_r2, output outer_r2, input ready);
  modport sink   (input valid, input mode, input inner_r2, input outer_r2, output ready);
endinterface

interface rlrl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rlrl_pkg::STATUS_W-1:0] status;
  logic [rlrl_pkg::LAYER_W-1:0]  lowest_layer;
  logic [rlrl_pkg::LAYER_W-1:0]  highest_layer;

  modport source (output valid, output status, output lowest_layer, output highest_layer,
                  input ready);
  modport sink   (input valid, input status, input lowest_layer, input highest_layer,
                  output ready);
endinterface

interface rlrl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rlrl_pkg::TOL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rlrl_ctrl.sv @@
`default_nettype none
module rlrl_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  rlrl_pkg::rlrl_sts_t sts,
  output rlrl_pkg::rlrl_cmd_t cmd
);
  import rlrl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_APPEND: begin
            if (sts.a_ge_b || sts.full) state_next = S_DONE;
            else if (sts.bc_zero) state_next = S_APP_GAP;
            else if (sts.a_lt_last) state_next = S_DONE;
            else if (sts.a_gt_tol) state_next = S_APP_GAP;
            else state_next = S_APP_LAYER;
          end
          MODE_QUERY: begin
            if (sts.q_empty || sts.q_outside) state_next = S_DONE;
            else if (sts.hi_lt_rmax) state_next = S_Q_SMAX;
            else state_next = S_Q_IMIN;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_APP_GAP:   state_next = S_APP_LAYER;
      S_APP_LAYER: state_next = S_DONE;
      S_Q_SMAX: begin
        if (sts.srch_done) state_next = S_Q_IMIN;
      end
      S_Q_IMIN: begin
        if (sts.lo_ge_rmin) state_next = S_Q_SMIN;
        else state_next = S_Q_OA;
      end
      S_Q_SMIN: begin
        if (sts.srch_done) state_next = S_Q_OA;
      end
      S_Q_OA:   state_next = S_Q_OB;
      S_Q_OB:   state_next = S_Q_OC;
      S_Q_OC:   state_next = S_Q_OD;
      S_Q_OD:   state_next = S_Q_OE;
      S_Q_OE:   state_next = S_Q_EVAL;
      S_Q_EVAL: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.srch  = SRCH_NONE;
    cmd.own   = OWN_NONE;
    cmd.res   = RES_OK0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_CLEAR: begin
            cmd.clr     = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res     = RES_OK0;
          end
          MODE_APPEND: begin
            if (sts.a_ge_b) begin
              cmd.res_set = 1'b1;
              cmd.res     = RES_BAD;
            end else if (sts.full) begin
              cmd.res_set = 1'b1;
              cmd.res     = RES_FULL;
            end else if (!sts.bc_zero && sts.a_lt_last) begin
              cmd.res_set = 1'b1;
              cmd.res     = RES_BAD;
            end
          end
          MODE_QUERY: begin
            if (sts.q_empty || sts.q_outside) begin
              cmd.res_set = 1'b1;
              cmd.res     = RES_NONE;
            end else if (sts.hi_lt_rmax) begin
              cmd.srch = SRCH_MAX;
            end else begin
              cmd.imax_dir = 1'b1;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            cmd.res     = RES_BAD;
          end
        endcase
      end
      S_APP_GAP: cmd.gap_wr = 1'b1;
      S_APP_LAYER: begin
        cmd.layer_wr = 1'b1;
        cmd.res_set  = 1'b1;
        cmd.res      = RES_IDX;
      end
      S_Q_SMAX: begin
        cmd.srch     = SRCH_STEP;
        cmd.imax_set = sts.srch_done;
      end
      S_Q_IMIN: begin
        if (sts.lo_ge_rmin) cmd.srch = SRCH_MIN;
        else cmd.imin_zero = 1'b1;
      end
      S_Q_SMIN: begin
        cmd.srch     = SRCH_STEP;
        cmd.imin_set = sts.srch_done;
      end
      S_Q_OA: cmd.own = OWN_A;
      S_Q_OB: cmd.own = OWN_B;
      S_Q_OC: cmd.own = OWN_C;
      S_Q_OD: cmd.own = OWN_D;
      S_Q_OE: cmd.own = OWN_E;
      S_Q_EVAL: begin
        cmd.res_set = 1'b1;
        cmd.res     = RES_QUERY;
      end
      S_DONE: cmd.load = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/rlrl_dp.sv @@
`default_nettype none
module rlrl_dp (
  input  wire                            clk,
  input  wire                            rst,
  input  rlrl_pkg::rlrl_cmd_t            cmd,
  output rlrl_pkg::rlrl_sts_t            sts,
  input  wire [rlrl_pkg::MODE_W-1:0]     req_mode,
  input  wire [rlrl_pkg::R2_W-1:0]       req_inner,
  input  wire [rlrl_pkg::R2_W-1:0]       req_outer,
  input  wire                            cfg_we,
  input  wire [rlrl_pkg::TOL_W-1:0]      cfg_data,
  input  wire                            out_ready,
  output logic                           out_valid,
  output logic [rlrl_pkg::STATUS_W-1:0]  out_status,
  output logic [rlrl_pkg::LAYER_W-1:0]   out_lowest,
  output logic [rlrl_pkg::LAYER_W-1:0]   out_highest
);
  import rlrl_pkg::*;

  mode_t              mode;
  logic [R2_W-1:0]    op_a, op_b;
  logic [R2_W-1:0]    first_bnd, last_bnd;
  logic [TOL_W-1:0]   gap_tol;
  logic [CNT_W-1:0]   bc;
  logic [LC_W-1:0]    lc;
  logic [R2_W-1:0]    s_v;
  logic [CNT_W-1:0]   s_lo, s_hi, s_mid;
  logic [ADDR_W-1:0]  imax, imin;
  logic [OWN_W-1:0]   lmin, lmax;
  status_t            res_status;
  logic [LAYER_W-1:0] res_lo, res_hi;
  status_t            res_status_next;
  logic [LAYER_W-1:0] res_lo_next, res_hi_next;

  logic [R2_W-1:0]  bnd_mem [TABLE_DEPTH];
  logic [OWN_W-1:0] own_mem [OWNER_DEPTH];

  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr, tbl_raddr;
  logic [R2_W-1:0]   tbl_wdata, tbl_rdata;
  logic              own_we;
  logic [ADDR_W-1:0] own_waddr, own_raddr;
  logic [OWN_W-1:0]  own_wdata, own_rdata;

  logic [CNT_W-1:0]  bc_m1;
  logic              s_done, go_hi;
  logic [CNT_W-1:0]  n_lo, n_hi, n_mid, init_hi, init_mid;
  logic [CNT_W:0]    n_sum;
  logic [R2_W:0]     last_tol;
  logic              q_bad, imin_nb;
  logic              swap_in;

  always_comb begin
    bc_m1    = bc - CNT_W'(1);
    last_tol = {1'b0, last_bnd} + (R2_W + 1)'(gap_tol);

    tbl_we    = cmd.gap_wr || cmd.layer_wr;
    tbl_waddr = bc[ADDR_W-1:0];
    tbl_wdata = cmd.gap_wr ? op_a : op_b;
    // the very first boundary has no interval below it
    own_we    = cmd.layer_wr || (cmd.gap_wr && (bc != '0));
    own_waddr = bc_m1[ADDR_W-1:0];
    own_wdata = cmd.gap_wr ? GAP_MARK : OWN_W'(lc);

    s_done   = (s_mid == s_lo);
    go_hi    = (s_v < tbl_rdata);
    n_lo     = go_hi ? s_lo : s_mid;
    n_hi     = go_hi ? s_mid : s_hi;
    n_sum    = {1'b0, n_lo} + {1'b0, n_hi};
    n_mid    = n_sum[CNT_W:1];
    init_hi  = (cmd.srch == SRCH_MIN) ? ({1'b0, imax} + CNT_W'(1)) : bc;
    init_mid = init_hi >> 1;

    case (cmd.srch)
      SRCH_MAX, SRCH_MIN: tbl_raddr = init_mid[ADDR_W-1:0];
      SRCH_STEP:          tbl_raddr = s_done ? s_mid[ADDR_W-1:0] : n_mid[ADDR_W-1:0];
      default:            tbl_raddr = s_mid[ADDR_W-1:0];
    endcase

    case (cmd.own)
      OWN_A:   own_raddr = imax;
      OWN_B:   own_raddr = imax - ADDR_W'(1);
      OWN_C:   own_raddr = imin;
      OWN_D:   own_raddr = imin + ADDR_W'(1);
      default: own_raddr = imin;
    endcase

    imin_nb = (({1'b0, imin} + CNT_W'(1)) < bc_m1);
    q_bad   = (lmin == GAP_MARK) || (lmax == GAP_MARK) || (lmin > lmax);
    swap_in = (mode_t'(req_mode) == MODE_QUERY) && (req_inner > req_outer);

    sts.mode       = mode;
    sts.a_ge_b     = (op_a >= op_b);
    sts.full       = (lc >= LC_W'(MAX_LAYERS)) || (bc > CNT_W'(TABLE_DEPTH - 2));
    sts.bc_zero    = (bc == '0);
    sts.a_lt_last  = (op_a < last_bnd);
    sts.a_gt_tol   = ({1'b0, op_a} > last_tol);
    sts.q_empty    = (lc == '0) || (bc < CNT_W'(2));
    sts.q_outside  = (op_a >= last_bnd) || (op_b <= first_bnd);
    sts.hi_lt_rmax = (op_b < last_bnd);
    sts.lo_ge_rmin = (op_a >= first_bnd);
    sts.srch_done  = s_done;
    sts.out_free   = !out_valid || out_ready;

    res_lo_next = '0;
    res_hi_next = '0;
    case (cmd.res)
      RES_OK0:  res_status_next = ST_OK;
      RES_BAD:  res_status_next = ST_BAD;
      RES_FULL: res_status_next = ST_FULL;
      RES_NONE: res_status_next = ST_NONE;
      RES_IDX: begin
        res_status_next = ST_OK;
        res_lo_next     = lc[LAYER_W-1:0];
        res_hi_next     = lc[LAYER_W-1:0];
      end
      RES_QUERY: begin
        if (q_bad) begin
          res_status_next = ST_NONE;
        end else begin
          res_status_next = ST_OK;
          res_lo_next     = lmin[LAYER_W-1:0];
          res_hi_next     = lmax[LAYER_W-1:0];
        end
      end
      default: res_status_next = ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) bnd_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= bnd_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (own_we) own_mem[own_waddr] <= own_wdata;
    own_rdata <= own_mem[own_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bc        <= '0;
      lc        <= '0;
      gap_tol   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) gap_tol <= cfg_data;
      if (cmd.clr) begin
        bc <= '0;
        lc <= '0;
      end
      if (cmd.gap_wr) bc <= bc + CNT_W'(1);
      if (cmd.layer_wr) begin
        bc <= bc + CNT_W'(1);
        lc <= lc + LC_W'(1);
      end
      if (cmd.load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode <= mode_t'(req_mode);
      op_a <= swap_in ? req_outer : req_inner;
      op_b <= swap_in ? req_inner : req_outer;
    end
    if (cmd.gap_wr && (bc == '0)) first_bnd <= op_a;
    if (cmd.layer_wr) last_bnd <= op_b;

    case (cmd.srch)
      SRCH_MAX, SRCH_MIN: begin
        s_v   <= (cmd.srch == SRCH_MAX) ? op_b : op_a;
        s_lo  <= '0;
        s_hi  <= init_hi;
        s_mid <= init_mid;
      end
      SRCH_STEP: begin
        if (!s_done) begin
          s_lo  <= n_lo;
          s_hi  <= n_hi;
          s_mid <= n_mid;
        end
      end
      default: ;
    endcase

    if (cmd.imax_set) imax <= s_mid[ADDR_W-1:0];
    if (cmd.imax_dir) imax <= bc[ADDR_W-1:0] - ADDR_W'(2);
    if (cmd.imin_set) imin <= s_mid[ADDR_W-1:0];
    if (cmd.imin_zero) imin <= '0;

    // a bound in a gap moves to the neighbouring layer inside the span: the outer bound inward, the inner bound outward
    case (cmd.own)
      OWN_B: lmax <= own_rdata;
      OWN_C: if ((lmax == GAP_MARK) && (imax != '0)) lmax <= own_rdata;
      OWN_D: lmin <= own_rdata;
      OWN_E: if ((lmin == GAP_MARK) && imin_nb) lmin <= own_rdata;
      default: ;
    endcase

    if (cmd.res_set) begin
      res_status <= res_status_next;
      res_lo     <= res_lo_next;
      res_hi     <= res_hi_next;
    end

    if (cmd.load) begin
      out_status  <= res_status;
      out_lowest  <= res_lo;
      out_highest <= res_hi;
    end
  end

endmodule
`default_nettype wire

@@ rtl/radial_layer_range_lookup_top.sv @@
`default_nettype none
// one item is in work at a time
// a query spends most of its time in up to two binary searches, one boundary-table read
// per step, followed by five interval-owner reads on its single port
// synchronous reset zeroes the boundary and layer counts and gap_tolerance at once,
// the tables themselves are not cleared and need no sweep
module radial_layer_range_lookup_top (
  input wire         clk,
  input wire         rst,
  rlrl_req_if.sink   req,
  rlrl_rsp_if.source rsp,
  rlrl_cfg_if.sink   cfg
);
  import rlrl_pkg::*;

  rlrl_cmd_t cmd;
  rlrl_sts_t sts;

  assign cfg.ready = 1'b1;

  rlrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlrl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_mode    (req.mode),
    .req_inner   (req.inner_r2),
    .req_outer   (req.outer_r2),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_lowest  (rsp.lowest_layer),
    .out_highest (rsp.highest_layer)
  );

endmodule
`default_nettype wire

@@ rtl/rlrl_checker.sv @@
`default_nettype none
`include "radial_layer_range_lookup_top_macros.svh"
module rlrl_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           req_valid,
  input wire                           req_ready,
  input wire                           rsp_valid,
  input wire                           rsp_ready,
  input wire [rlrl_pkg::STATUS_W-1:0]  rsp_status,
  input wire [rlrl_pkg::LAYER_W-1:0]   rsp_lowest,
  input wire [rlrl_pkg::LAYER_W-1:0]   rsp_highest
);
  import rlrl_pkg::*;

  // one item at a time: the input closes right after a beat
  `RLRL_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "input beat not blocked")

  `RLRL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_lowest) && $stable(rsp_highest), "stalled result changed")

  // error statuses carry no layer numbers
  `RLRL_ASSERT(a_err_zero, rsp_valid && (rsp_status != ST_OK) |-> (rsp_lowest == '0) && (rsp_highest == '0), "layer fields set on error")

  `RLRL_ASSERT(a_ok_order, rsp_valid && (rsp_status == ST_OK) |-> rsp_lowest <= rsp_highest, "lowest layer above highest")

  `RLRL_ASSERT_ALWAYS(a_rst_quiet, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind radial_layer_range_lookup_top rlrl_checker u_rlrl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_lowest  (rsp.lowest_layer),
  .rsp_highest (rsp.highest_layer)
);
`default_nettype wire

@@ sim/layer_lookup_checker.sv @@
`timescale 1ns / 100ps
module layer_lookup_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                req_valid,
  input  wire                                req_ready,
  input  wire [rlrl_pkg::MODE_W-1:0]         req_mode,
  input  wire [rlrl_pkg::R2_W-1:0]           req_inner_r2,
  input  wire [rlrl_pkg::R2_W-1:0]           req_outer_r2,
  input  wire                                rsp_valid,
  input  wire                                rsp_ready,
  input  wire [rlrl_pkg::STATUS_W-1:0]       rsp_status,
  input  wire [rlrl_pkg::LAYER_W-1:0]        rsp_lowest,
  input  wire [rlrl_pkg::LAYER_W-1:0]        rsp_highest,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire [rlrl_pkg::TOL_W-1:0]          cfg_data,
  output int unsigned                        outstanding,
  output int unsigned                        fail_count
);
  import rlrl_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [LAYER_W-1:0] lowest;
    logic [LAYER_W-1:0] highest;
  } layer_answer_t;

  logic [R2_W-1:0]  bound_r2 [TABLE_DEPTH];
  logic [OWN_W-1:0] owner_of [OWNER_DEPTH];
  int unsigned      bound_count;
  int unsigned      layer_total;
  logic [TOL_W-1:0] tolerance;
  layer_answer_t    layer_answers [$];

  // highest index in [lo, hi) whose boundary is at or below v
  function automatic int unsigned find_slot(input logic [R2_W-1:0] v,
                                            input int unsigned lo, input int unsigned hi);
    int unsigned mid;
    mid = (lo + hi) >> 1;
    while (mid != lo) begin
      if (v < bound_r2[mid]) hi = mid;
      else lo = mid;
      mid = (lo + hi) >> 1;
    end
    return mid;
  endfunction

  task automatic resolve_item(input mode_t m, input logic [R2_W-1:0] a,
                              input logic [R2_W-1:0] b);
    layer_answer_t   ans;
    logic [R2_W-1:0] lo_r2;
    logic [R2_W-1:0] hi_r2;
    logic [R2_W-1:0] last_r2;
    int unsigned     imin;
    int unsigned     imax;
    int unsigned     lmin;
    int unsigned     lmax;
    ans = '{ST_OK, '0, '0};
    case (m)
      MODE_CLEAR: begin
        bound_count = 0;
        layer_total = 0;
      end
      MODE_APPEND: begin
        if (a >= b) begin
          ans.status = ST_BAD;
        end else if (layer_total >= MAX_LAYERS || bound_count + 2 > TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else if (bound_count == 0 || layer_total == 0) begin
          bound_r2[0] = a;
          bound_r2[1] = b;
          owner_of[0] = '0;
          bound_count = 2;
          layer_total = 1;
        end else begin
          last_r2 = bound_r2[bound_count - 1];
          if (a < last_r2) begin
            ans.status = ST_BAD;
          end else begin
            // beyond the slack the space up to the new inner radius becomes a gap
            if ({1'b0, a} > {1'b0, last_r2} + tolerance) begin
              owner_of[bound_count - 1] = GAP_MARK;
              bound_r2[bound_count] = a;
              bound_count++;
            end
            ans.lowest = LAYER_W'(layer_total);
            ans.highest = LAYER_W'(layer_total);
            owner_of[bound_count - 1] = OWN_W'(layer_total);
            bound_r2[bound_count] = b;
            bound_count++;
            layer_total++;
          end
        end
      end
      MODE_QUERY: begin
        lo_r2 = (a > b) ? b : a;
        hi_r2 = (a > b) ? a : b;
        if (layer_total == 0 || bound_count < 2) begin
          ans.status = ST_NONE;
        end else if (lo_r2 >= bound_r2[bound_count - 1] || hi_r2 <= bound_r2[0]) begin
          ans.status = ST_NONE;
        end else begin
          imax = (hi_r2 < bound_r2[bound_count - 1]) ? find_slot(hi_r2, 0, bound_count)
                                                     : bound_count - 2;
          imin = (lo_r2 >= bound_r2[0]) ? find_slot(lo_r2, 0, imax + 1) : 0;
          lmax = owner_of[imax];
          lmin = owner_of[imin];
          // a bound inside a gap snaps to the layer just inside the ray's span
          if (lmax == GAP_MARK && imax > 0) lmax = owner_of[imax - 1];
          if (lmin == GAP_MARK && imin + 1 < bound_count - 1) lmin = owner_of[imin + 1];
          if (lmin == GAP_MARK || lmax == GAP_MARK || lmin > lmax) begin
            ans.status = ST_NONE;
          end else begin
            ans.lowest = LAYER_W'(lmin);
            ans.highest = LAYER_W'(lmax);
          end
        end
      end
      default: begin
        ans.status = ST_BAD;
      end
    endcase
    layer_answers.insert(layer_answers.size(), ans);
  endtask

  always @(posedge clk) begin : track
    layer_answer_t got;
    layer_answer_t want;
    if (rst) begin
      bound_count = 0;
      layer_total = 0;
      tolerance = '0;
      layer_answers.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got = '{status_t'(rsp_status), rsp_lowest, rsp_highest};
        if (layer_answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected result beat: status %0d lowest %0d highest %0d",
                     $realtime, got.status, got.lowest, got.highest);
        end else begin
          want = layer_answers.pop_front();
          if (got.status != want.status || got.lowest != want.lowest ||
              got.highest != want.highest) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t result differs: expected status %0d lowest %0d highest %0d, %s %0d %0d %0d",
                       $realtime, want.status, want.lowest, want.highest, "got",
                       got.status, got.lowest, got.highest);
          end
        end
      end
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (req_valid && req_ready) resolve_item(mode_t'(req_mode), req_inner_r2, req_outer_r2);
    end
    outstanding <= layer_answers.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import rlrl_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int          PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int          SETTLE       = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  rlrl_req_if req ();
  rlrl_rsp_if rsp ();
  rlrl_cfg_if cfg ();

  int unsigned outstanding;
  int unsigned fail_count;

  radial_layer_range_lookup_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  layer_lookup_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_mode     (req.mode),
    .req_inner_r2 (req.inner_r2),
    .req_outer_r2 (req.outer_r2),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_lowest   (rsp.lowest_layer),
    .rsp_highest  (rsp.highest_layer),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready),
    .cfg_data     (cfg.data),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  logic             idle_on = 1'b1;
  logic [TOL_W-1:0] cur_tol;
  logic [R2_W-1:0]  bound_hist [$];
  int unsigned      sent_per_mode [4];
  int unsigned      sent_total;
  int unsigned      tol_writes;
  int unsigned      stall_left = 0;

  // receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("radial_layer_range_lookup_top: mismatch");
    $finish;
  end

  // leaves valid high at the accepting edge so the next beat can follow back to back
  task automatic send_item(input mode_t m, input logic [R2_W-1:0] a,
                           input logic [R2_W-1:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= m;
    req.inner_r2 <= a;
    req.outer_r2 <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_per_mode[m]++;
    sent_total++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_tol = v;
    tol_writes++;
  endtask

  function automatic logic [R2_W-1:0] pick_radius(input longint unsigned span_lo,
                                                  input longint unsigned span_hi);
    longint unsigned wide;
    int unsigned     roll;
    roll = $urandom_range(0, 19);
    wide = {$urandom, $urandom};
    if (roll < 7 && bound_hist.size() != 0)
      return bound_hist[$urandom_range(0, bound_hist.size() - 1)]
             + R2_W'($urandom_range(0, 2)) - R2_W'(1);
    if (roll < 16) return R2_W'(span_lo + wide % (span_hi - span_lo + 1));
    if (roll < 19) return $urandom;
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // clear, build an ascending stack of layers with assorted gaps, occasional bad appends and queries, then query it
  task automatic run_sequence(input logic quiet);
    longint unsigned cur;
    longint unsigned first;
    longint unsigned a;
    longint unsigned b;
    longint unsigned stepmax;
    longint unsigned span_lo;
    longint unsigned span_hi;
    int unsigned     n_layers;
    int unsigned     roll;
    idle_on = !quiet && ($urandom_range(0, 3) != 0);
    bound_hist.delete();
    send_item(MODE_CLEAR, $urandom, $urandom);
    roll = $urandom_range(0, 19);
    if (roll < 14) n_layers = $urandom_range(1, 8);
    else if (roll < 18) n_layers = $urandom_range(9, 40);
    else n_layers = $urandom_range(62, 67);
    if (n_layers > 40) begin
      stepmax = 64'd1 << $urandom_range(0, 20);
      first = $urandom_range(0, 1 << 20);
    end else begin
      stepmax = 64'd1 << $urandom_range(0, 27);
      first = ($urandom_range(0, 3) == 0) ? 0 : ($urandom >> $urandom_range(0, 31));
    end
    cur = first;
    for (int i = 0; i < n_layers; i++) begin
      case ($urandom_range(0, 5))
        0: a = cur;
        1: a = cur + $urandom_range(0, cur_tol);
        2: a = cur + cur_tol;
        3: a = cur + cur_tol + 1;
        default: a = cur + cur_tol + 1 + ($urandom % stepmax);
      endcase
      if (i == 0) a = cur;
      b = a + 1 + ($urandom % stepmax);
      if (b > 64'hFFFF_FFFF) break;
      if (i != 0 && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) != 0) send_item(MODE_APPEND, R2_W'(b), R2_W'(a));
        else send_item(MODE_APPEND, R2_W'(cur - 1), R2_W'(b));
      end
      send_item(MODE_APPEND, R2_W'(a), R2_W'(b));
      bound_hist.insert(bound_hist.size(), R2_W'(a));
      bound_hist.insert(bound_hist.size(), R2_W'(b));
      cur = b;
      if ($urandom_range(0, 7) == 0)
        send_item(MODE_QUERY, pick_radius(first, cur), pick_radius(first, cur));
    end
    span_lo = (first > stepmax) ? first - stepmax : 0;
    span_hi = (cur + stepmax > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cur + stepmax;
    repeat ($urandom_range(1, 12))
      send_item(MODE_QUERY, pick_radius(span_lo, span_hi), pick_radius(span_lo, span_hi));
  endtask

  initial begin
    int unsigned phase_start;
    req.valid = 1'b0;
    req.mode = MODE_CLEAR;
    req.inner_r2 = '0;
    req.outer_r2 = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    cur_tol = '0;
    sent_total = 0;
    tol_writes = 0;
    foreach (sent_per_mode[k]) sent_per_mode[k] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, reserved mode, bad layers, touching, slack, gaps, extremes
    write_tolerance(16);
    send_item(MODE_QUERY, 5, 10);
    send_item(MODE_RSVD, '1, '1);
    send_item(MODE_APPEND, 7, 7);
    send_item(MODE_APPEND, 32'hFFFF_FFFF, 0);
    send_item(MODE_APPEND, 100, 200);
    send_item(MODE_APPEND, 200, 300);
    send_item(MODE_APPEND, 250, 400);
    send_item(MODE_APPEND, 316, 400);
    send_item(MODE_APPEND, 417, 1000);
    send_item(MODE_QUERY, 150, 700);
    send_item(MODE_QUERY, 700, 150);
    send_item(MODE_QUERY, 0, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, 1000, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, 0, 100);
    send_item(MODE_QUERY, 405, 410);
    send_item(MODE_QUERY, 405, 500);
    send_item(MODE_APPEND, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
    send_item(MODE_CLEAR, $urandom, $urandom);
    send_item(MODE_QUERY, 0, 32'hFFFF_FFFF);
    send_item(MODE_APPEND, 0, 32'hFFFF_FFFF);
    send_item(MODE_QUERY, 0, 0);
    send_item(MODE_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_tolerance('0);
        1: write_tolerance('1);
        2: write_tolerance(TOL_W'($urandom_range(0, 15)));
        default: write_tolerance(TOL_W'($urandom_range(0, 65535)));
      endcase
      phase_start = sent_total;
      while (sent_total - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          idle_on = (ph != PHASES - 1);
          send_item(mode_t'($urandom_range(0, 3)), $urandom, $urandom);
        end else begin
          run_sequence(ph == PHASES - 1);
        end
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d clears, %0d appends, %0d queries, %0d reserved-mode beats",
             sent_per_mode[MODE_CLEAR], sent_per_mode[MODE_APPEND],
             sent_per_mode[MODE_QUERY], sent_per_mode[MODE_RSVD]);
    $display("across %0d gap tolerance settings, both extremes included", tol_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("radial_layer_range_lookup_top: match");
    end else begin
      $display("radial_layer_range_lookup_top: mismatch");
    end
    $finish;
  end

endmodule
